### rtl/pcn_pkg.sv
// Package for the per-channel normaliser: widths, register indexes and the
// beat structures handed between stages. No dependencies.
`default_nettype none

package pcn_pkg;

   localparam int SAMPLE_W             = 32;
   localparam int DIFF_W               = SAMPLE_W + 1;
   localparam int STD_W                = 32;
   localparam int PARAM_W              = 64;
   localparam int CHAN_W               = 2;
   localparam int COUNT_REG_W          = 3;
   localparam int PLANE_SIZE_W         = 25;
   localparam int CSR_ADDR_W           = 3;
   localparam int RSP_USER_W           = 4;
   localparam int FRAC_BITS            = 16;
   localparam int DIV_STEPS            = 32;
   localparam int MAX_CHANNELS_DEF     = 4;
   localparam int PLANE_COUNT_BITS_DEF = 24;

   localparam logic [PARAM_W-1:0]  PARAM_RESET = PARAM_W'(65536);
   localparam logic [SAMPLE_W-1:0] SAT_MAX     = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic [SAMPLE_W-1:0] SAT_MIN     = {1'b1, {(SAMPLE_W-1){1'b0}}};

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_LAYOUT     = 3'd0,
      CSR_CHAN_COUNT = 3'd1,
      CSR_PLANE_SIZE = 3'd2,
      CSR_CHAN0      = 3'd3,
      CSR_CHAN1      = 3'd4,
      CSR_CHAN2      = 3'd5,
      CSR_CHAN3      = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic signed [DIFF_W-1:0] diff;
      logic [STD_W-1:0]         sd;
      logic [CHAN_W-1:0]        chan;
      logic                     zero;
   } pcn_front_type;

   typedef struct packed {
      logic [STD_W-1:0]  mag;
      logic [STD_W-1:0]  den;
      logic              neg;
      logic [CHAN_W-1:0] chan;
      logic              zero;
   } pcn_mag_type;

   typedef struct packed {
      logic [STD_W-1:0]  rem;
      logic [STD_W-1:0]  dq;
      logic [STD_W-1:0]  den;
      logic              neg;
      logic              ovf;
      logic [CHAN_W-1:0] chan;
      logic              zero;
   } pcn_div_type;

endpackage

`default_nettype wire

### rtl/pcn_front.sv
// Configuration registers, channel and plane counters, and the entry stage
// that forms x - mean. Depends on pcn_pkg.
`default_nettype none

module pcn_front #(
   parameter int MAX_CHANNELS     = pcn_pkg::MAX_CHANNELS_DEF,
   parameter int PLANE_COUNT_BITS = pcn_pkg::PLANE_COUNT_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [pcn_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [pcn_pkg::PARAM_W-1:0]     csr_wdata,
   input  wire logic                            up_valid,
   output logic                                 up_ready,
   input  wire logic [pcn_pkg::SAMPLE_W-1:0]    up_sample,
   input  wire logic                            up_start,
   output logic                                 dn_valid,
   input  wire logic                            dn_ready,
   output pcn_pkg::pcn_front_type               dn_data
);
   import pcn_pkg::*;

   localparam int CMP_W = (PLANE_COUNT_BITS + 1 > PLANE_SIZE_W) ?
                          PLANE_COUNT_BITS + 1 : PLANE_SIZE_W;

   logic                        layout_ff;
   logic [COUNT_REG_W-1:0]      count_ff;
   logic [PLANE_SIZE_W-1:0]     plane_size_ff;
   logic [PARAM_W-1:0]          params_ff [MAX_CHANNELS];
   logic [CHAN_W-1:0]           chan_ff, chan_in;
   logic [PLANE_COUNT_BITS-1:0] pos_ff, pos_in;
   logic                        valid_ff;
   pcn_front_type               data_ff, data_in;

   logic                        accept;
   logic [CHAN_W-1:0]           chan_cur, chan_adv;
   logic [PLANE_COUNT_BITS-1:0] pos_cur;
   logic [PLANE_COUNT_BITS:0]   pos_inc;
   logic [COUNT_REG_W-1:0]      eff_count, chan_inc;
   logic                        plane_end;
   logic [PARAM_W-1:0]          sel;
   logic [SAMPLE_W-1:0]         mean;

   assign up_ready = !valid_ff || dn_ready;
   assign accept   = up_valid && up_ready;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   always_comb begin
      chan_cur = up_start ? '0 : chan_ff;
      pos_cur  = up_start ? '0 : pos_ff;

      sel = PARAM_RESET;
      for (int k = 0; k < MAX_CHANNELS; k++) begin
         if (chan_cur == CHAN_W'(k)) begin
            sel = params_ff[k];
         end
      end

      if (count_ff == '0) begin
         eff_count = COUNT_REG_W'(1);
      end else if (count_ff > COUNT_REG_W'(MAX_CHANNELS)) begin
         eff_count = COUNT_REG_W'(MAX_CHANNELS);
      end else begin
         eff_count = count_ff;
      end
      chan_inc = COUNT_REG_W'(chan_cur) + COUNT_REG_W'(1);
      chan_adv = (chan_inc >= eff_count) ? '0 : chan_inc[CHAN_W-1:0];

      pos_inc   = {1'b0, pos_cur} + {{PLANE_COUNT_BITS{1'b0}}, 1'b1};
      plane_end = (CMP_W'(pos_inc) >= CMP_W'(plane_size_ff)) ||
                  pos_inc[PLANE_COUNT_BITS];

      if (layout_ff) begin
         if (plane_end) begin
            pos_in  = '0;
            chan_in = chan_adv;
         end else begin
            pos_in  = pos_inc[PLANE_COUNT_BITS-1:0];
            chan_in = chan_cur;
         end
      end else begin
         pos_in  = pos_cur;
         chan_in = chan_adv;
      end

      mean         = sel[PARAM_W-1:STD_W];
      data_in.diff = $signed({up_sample[SAMPLE_W-1], up_sample}) -
                     $signed({mean[SAMPLE_W-1], mean});
      data_in.sd   = sel[STD_W-1:0];
      data_in.chan = chan_cur;
      data_in.zero = (sel[STD_W-1:0] == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff     <= 1'b0;
         count_ff      <= COUNT_REG_W'(3);
         plane_size_ff <= PLANE_SIZE_W'(1);
         for (int k = 0; k < MAX_CHANNELS; k++) begin
            params_ff[k] <= PARAM_RESET;
         end
         chan_ff  <= '0;
         pos_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index_type'(csr_addr))
               CSR_LAYOUT:     layout_ff     <= csr_wdata[0];
               CSR_CHAN_COUNT: count_ff      <= csr_wdata[COUNT_REG_W-1:0];
               CSR_PLANE_SIZE: plane_size_ff <= csr_wdata[PLANE_SIZE_W-1:0];
               default: ;
            endcase
         end
         for (int k = 0; k < MAX_CHANNELS; k++) begin
            if (csr_wr_en &&
                csr_addr == CSR_ADDR_W'(CSR_CHAN0) + CSR_ADDR_W'(k)) begin
               params_ff[k] <= csr_wdata;
            end
         end
         if (accept) begin
            chan_ff <= chan_in;
            pos_ff  <= pos_in;
         end
         if (up_ready) begin
            valid_ff <= up_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

### rtl/pcn_prep.sv
// Two stages ahead of the divider row: magnitudes and sign, then the
// overflow check and the initial remainder. Depends on pcn_pkg.
`default_nettype none

module pcn_prep (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              up_valid,
   output logic                   up_ready,
   input  pcn_pkg::pcn_front_type up_data,
   output logic                   dn_valid,
   input  wire logic              dn_ready,
   output pcn_pkg::pcn_div_type   dn_data
);
   import pcn_pkg::*;

   logic              b_valid_ff, c_valid_ff;
   pcn_mag_type       b_data_ff, b_data_in;
   pcn_div_type       c_data_ff, c_data_in;
   logic              b_ready, c_ready;
   logic [DIFF_W-1:0] diff_abs;

   assign c_ready  = !c_valid_ff || dn_ready;
   assign b_ready  = !b_valid_ff || c_ready;
   assign up_ready = b_ready;
   assign dn_valid = c_valid_ff;
   assign dn_data  = c_data_ff;

   always_comb begin
      diff_abs       = up_data.diff[DIFF_W-1] ? (~up_data.diff + DIFF_W'(1))
                                              : up_data.diff;
      b_data_in.mag  = diff_abs[STD_W-1:0];
      b_data_in.den  = up_data.sd[STD_W-1] ? (~up_data.sd + STD_W'(1)) : up_data.sd;
      b_data_in.neg  = up_data.diff[DIFF_W-1] ^ up_data.sd[STD_W-1];
      b_data_in.chan = up_data.chan;
      b_data_in.zero = up_data.zero;

      c_data_in.rem  = STD_W'(b_data_ff.mag >> FRAC_BITS);
      c_data_in.dq   = b_data_ff.mag << FRAC_BITS;
      c_data_in.den  = b_data_ff.den;
      c_data_in.neg  = b_data_ff.neg;
      c_data_in.ovf  = (STD_W'(b_data_ff.mag >> FRAC_BITS) >= b_data_ff.den);
      c_data_in.chan = b_data_ff.chan;
      c_data_in.zero = b_data_ff.zero;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (b_ready) begin
            b_valid_ff <= up_valid;
         end
         if (c_ready) begin
            c_valid_ff <= b_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (b_ready && up_valid) begin
         b_data_ff <= b_data_in;
      end
      if (c_ready && b_valid_ff) begin
         c_data_ff <= c_data_in;
      end
   end

endmodule

`default_nettype wire

### rtl/pcn_div_cell.sv
// One cell of the divider row: one restoring step, one quotient bit per beat.
// Depends on pcn_pkg.
`default_nettype none

module pcn_div_cell (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            up_valid,
   output logic                 up_ready,
   input  pcn_pkg::pcn_div_type up_data,
   output logic                 dn_valid,
   input  wire logic            dn_ready,
   output pcn_pkg::pcn_div_type dn_data
);
   import pcn_pkg::*;

   logic             valid_ff;
   pcn_div_type      data_ff, data_in;
   logic [STD_W:0]   shifted, trial;

   assign up_ready = !valid_ff || dn_ready;
   assign dn_valid = valid_ff;
   assign dn_data  = data_ff;

   always_comb begin
      data_in = up_data;
      shifted = {up_data.rem, up_data.dq[STD_W-1]};
      trial   = shifted - {1'b0, up_data.den};
      if (!trial[STD_W]) begin
         data_in.rem = trial[STD_W-1:0];
         data_in.dq  = {up_data.dq[STD_W-2:0], 1'b1};
      end else begin
         data_in.rem = shifted[STD_W-1:0];
         data_in.dq  = {up_data.dq[STD_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

`default_nettype wire

### rtl/pcn_out.sv
// Result stage: applies the sign, clamps to 32 bits, flags zero std and
// holds the result beat. Depends on pcn_pkg.
`default_nettype none

module pcn_out (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           up_valid,
   output logic                                up_ready,
   input  pcn_pkg::pcn_div_type                up_data,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [pcn_pkg::SAMPLE_W-1:0]        rsp_tdata,
   output logic [pcn_pkg::RSP_USER_W-1:0]      rsp_tuser
);
   import pcn_pkg::*;

   logic                  valid_ff;
   logic [SAMPLE_W-1:0]   value_ff, value_in;
   logic [RSP_USER_W-1:0] user_ff, user_in;
   logic                  sat;

   assign up_ready   = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = value_ff;
   assign rsp_tuser  = user_ff;

   always_comb begin
      priority if (up_data.zero) begin
         sat      = 1'b0;
         value_in = '0;
      end else if (up_data.ovf) begin
         sat      = 1'b1;
         value_in = up_data.neg ? SAT_MIN : SAT_MAX;
      end else if (!up_data.neg) begin
         sat      = up_data.dq[SAMPLE_W-1];
         value_in = sat ? SAT_MAX : up_data.dq;
      end else begin
         sat      = up_data.dq[SAMPLE_W-1] && (|up_data.dq[SAMPLE_W-2:0]);
         value_in = sat ? SAT_MIN : (~up_data.dq + SAMPLE_W'(1));
      end
      user_in = {sat, up_data.zero, up_data.chan};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready && up_valid) begin
         value_ff <= value_in;
         user_ff  <= user_in;
      end
   end

endmodule

`default_nettype wire

### rtl/per_channel_normalizer_core.sv
// Top level of the per-channel normaliser: front stage, preparation stages,
// divider cell row and result stage. Depends on pcn_pkg and all pcn_ modules.
//
// Use: each req_ beat carries one tensor element (Q16.16) in memory order;
// req_tuser high restarts the channel and plane counters at that element.
// Each rsp_ beat carries (x - mean[c]) / std[c] in Q16.16, truncated toward
// zero and clamped to 32 bits, with channel, zero-std and saturation flags.
// csr_ writes set layout, channel count, plane size and per-channel mean/std;
// write them only while no element is in flight.
// Path: an accepted req_ beat reaches rsp_tvalid through the row of 32 divider
// cells (one quotient bit each) plus four other stages.
// Throughput: one element per cycle while rsp_tready stays high; every stage
// holds one beat and moves it on when the next stage is free, so bubbles
// close up. Stall: with rsp_tready low the result beat holds; stages behind it
// keep filling until the row is full, then req_tready falls.
// Reset: synchronous; empties the pipeline, clears the counters and loads the
// register reset values (3 channels, interleaved, mean 0, std 1.0).
`default_nettype none

module per_channel_normalizer_core #(
   parameter int MAX_CHANNELS     = pcn_pkg::MAX_CHANNELS_DEF,
   parameter int PLANE_COUNT_BITS = pcn_pkg::PLANE_COUNT_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [pcn_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [pcn_pkg::PARAM_W-1:0]     csr_wdata,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // sample[31:0]
   input  wire logic [pcn_pkg::SAMPLE_W-1:0]    req_tdata,
   // start_of_tensor
   input  wire logic                            req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // normalized[31:0]
   output logic [pcn_pkg::SAMPLE_W-1:0]         rsp_tdata,
   // channel_index[1:0], std_zero_error[2], saturated[3]
   output logic [pcn_pkg::RSP_USER_W-1:0]       rsp_tuser
);
   import pcn_pkg::*;

   logic          front_valid, front_ready;
   pcn_front_type front_data;
   logic [DIV_STEPS:0] div_valid, div_ready;
   pcn_div_type   div_link [DIV_STEPS+1];

   pcn_front #(
      .MAX_CHANNELS     (MAX_CHANNELS),
      .PLANE_COUNT_BITS (PLANE_COUNT_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .up_valid  (req_tvalid),
      .up_ready  (req_tready),
      .up_sample (req_tdata),
      .up_start  (req_tuser),
      .dn_valid  (front_valid),
      .dn_ready  (front_ready),
      .dn_data   (front_data)
   );

   pcn_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .up_valid (front_valid),
      .up_ready (front_ready),
      .up_data  (front_data),
      .dn_valid (div_valid[0]),
      .dn_ready (div_ready[0]),
      .dn_data  (div_link[0])
   );

   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_cell
      pcn_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (div_valid[k]),
         .up_ready (div_ready[k]),
         .up_data  (div_link[k]),
         .dn_valid (div_valid[k+1]),
         .dn_ready (div_ready[k+1]),
         .dn_data  (div_link[k+1])
      );
   end

   pcn_out u_out (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (div_valid[DIV_STEPS]),
      .up_ready   (div_ready[DIV_STEPS]),
      .up_data    (div_link[DIV_STEPS]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire
